// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, a rotate function and shared types.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       no_data;
    logic       is_final;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Short first-in first-out queue between the input side and the engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_queue
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sha_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sha_item_t out_item
);

  sha_item_t            slots [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     fill;
  logic                 push;
  logic                 pop;

  assign in_ready  = (fill != (QueueAw+1)'(QueueDepth));
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  `ASSERT_IMPL(a_fill_bound, clk, rst, fill <= (QueueAw+1)'(QueueDepth), "queue overfilled")
  `ASSERT_IMPL(a_ptr_gap, clk, rst, QueueAw'(wr_ptr - rd_ptr) == fill[QueueAw-1:0], "pointer gap")

endmodule

// File: rtl/sha256_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 engine
// Buffers bytes, runs the compression one round per cycle, pads and emits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_engine
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  sha_item_t   item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha_state_t   state, state_next;
  logic [31:0]  hash [8];
  logic [31:0]  work [8];
  logic [31:0]  win  [16];
  logic [60:0]  byte_count;
  logic [5:0]   round;
  logic [5:0]   pos;
  logic         finishing;
  logic         second_pad;
  logic         padded;
  logic [63:0]  bits;
  logic [511:0] pad_block;
  logic [31:0]  w_cur, s0, s1, t1, t2, w15, w2;
  logic         take;

  assign item_ready = (state == ST_IDLE);
  assign take       = item_valid && item_ready;
  assign bits       = {byte_count, 3'b000};

  assign w15   = win[round[3:0] + 4'd1];
  assign w2    = win[round[3:0] + 4'd14];
  assign s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign w_cur = (round < 6'd16) ? win[round[3:0]]
               : win[round[3:0]] + s0 + win[round[3:0] + 4'd9] + s1;
  assign t1 = work[7] + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25))
            + (work[6] ^ (work[4] & (work[5] ^ work[6]))) + RoundK[round] + w_cur;
  assign t2 = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22))
            + ((work[0] & work[1]) | (work[2] & (work[0] | work[1])));

  assign out_valid   = (state == ST_EMIT);
  assign digest_word = hash[round[2:0]];
  assign word_index  = round[2:0];
  assign last_word   = (round[2:0] == 3'd7);

  always_comb begin
    pad_block = '0;
    for (int k = 0; k < 64; k++) begin
      pad_block[511-8*k -: 8] = win[k >> 2][31-8*(k & 3) -: 8];
      if (second_pad) begin
        pad_block[511-8*k -: 8] = 8'h00;
      end else if (6'(k) == pos) begin
        pad_block[511-8*k -: 8] = PadByte;
      end else if (6'(k) > pos) begin
        pad_block[511-8*k -: 8] = 8'h00;
      end
      if (k >= 56 && !(pos >= LenStart && !second_pad)) begin
        pad_block[511-8*k -: 8] = bits[8*(63-k) +: 8];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (!item.no_data && pos == 6'd63) begin
            state_next = ST_ROUND;
          end else if (item.is_final) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (!padded) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_PAD: begin
        state_next = ST_ROUND;
      end
      ST_EMIT: begin
        if (out_ready && round[2:0] == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pos        <= '0;
      round      <= '0;
      finishing  <= 1'b0;
      second_pad <= 1'b0;
      padded     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= InitHash[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          round <= '0;
          if (take) begin
            finishing <= item.is_final;
            if (!item.no_data) begin
              win[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.byte_value;
              byte_count <= byte_count + 61'd1;
              pos        <= pos + 6'd1;
            end
            if (!item.no_data && pos == 6'd63) begin
              for (int i = 0; i < 8; i++) begin
                work[i] <= hash[i];
              end
            end
          end
        end
        ST_ROUND: begin
          if (round >= 6'd16) begin
            win[round[3:0]] <= w_cur;
          end
          for (int i = 1; i < 8; i++) begin
            work[i] <= work[i-1];
          end
          work[4] <= work[3] + t1;
          work[0] <= t1 + t2;
          round   <= round + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          round <= '0;
        end
        ST_PAD: begin
          for (int i = 0; i < 16; i++) begin
            win[i] <= pad_block[511-32*i -: 32];
          end
          for (int i = 0; i < 8; i++) begin
            work[i] <= hash[i];
          end
          second_pad <= (pos >= LenStart) && !second_pad;
          padded     <= !((pos >= LenStart) && !second_pad);
          round      <= '0;
        end
        ST_EMIT: begin
          if (out_ready) begin
            round <= round + 6'd1;
            if (round[2:0] == 3'd7) begin
              byte_count <= '0;
              pos        <= '0;
              finishing  <= 1'b0;
              second_pad <= 1'b0;
              padded     <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= InitHash[i];
              end
            end
          end
        end
        default: begin
          round <= '0;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, item_ready |-> !out_valid, "ready while emitting")
  `ASSERT_IMPL(a_emit_round, clk, rst, out_valid |-> round[5:3] == 3'd0, "emit index out of range")
  `ASSERT_IMPL(a_pos_count, clk, rst, pos == byte_count[5:0], "position disagrees with count")

endmodule

// File: rtl/sha256_stream_hasher_core.sv
// Sequence: an item that fills a block starts a compression; a final item adds one or two
// further compressions, each after a padding step, before the first digest word.
// Throughput: one byte per cycle into the queue while not full, and at the engine while
// idle; each full block then holds the engine in the shared round unit for its compression.
// Reset: synchronous; clears the queue, the byte count and the chaining words.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide SHA-256 with an input queue feeding an iterative round engine.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        no_data,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha_item_t in_item;
  sha_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  assign in_item = '{byte_value: byte_value, no_data: no_data, is_final: is_final};

  sha256_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  sha256_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule

// File: bench/tb_sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages byte by byte into the hasher and compares every digest
// word against a behavioural SHA-256 model, under several handshake loads.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_core;
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_value;
  logic        no_data;
  logic        is_final;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_bytes;
  digest_out_t  expected_words [$];
  int           error_count;
  int           items_sent;
  int           digests_seen;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;

  sha256_stream_hasher_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .no_data(no_data), .is_final(is_final),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
    msg_bytes = '0;
  endtask

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic predict_digest(logic [7:0] b, logic nd, logic fin);
    int          pos;
    logic [63:0] bit_len;
    if (!nd) begin
      pos = int'(msg_bytes[5:0]);
      msg_block[pos] = b;
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 63) compress_msg_block();
    end
    if (!fin) return;
    pos = int'(msg_bytes[5:0]);
    bit_len = {msg_bytes, 3'b000};
    msg_block[pos] = PadByte;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_msg_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++)
      expected_words.push_back('{hash_state[i], 3'(i), i == 7});
    hash_reset();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_item(logic [7:0] b, logic nd, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    no_data    <= nd;
    is_final   <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(b, nd, fin);
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    digest_out_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", digest_word, 32'h0);
        end else begin
          want = expected_words.pop_front();
          if (digest_word !== want.word) report_mismatch("digest_word", digest_word, want.word);
          if (word_index !== want.index)
            report_mismatch("word_index", 32'(word_index), 32'(want.index));
          if (last_word !== want.last)
            report_mismatch("last_word", 32'(last_word), 32'(want.last));
          if (want.last) digests_seen++;
        end
      end
      if (idle_cycles > 20000) begin
        $display("tb_sha256_stream_hasher_core: errors");
        $finish;
      end
    end
  end

  task automatic send_message(int len, bit fin_empty, bit trail_noise);
    for (int i = 0; i < len; i++) begin
      if (trail_noise && $urandom_range(9) == 0) send_item(8'($urandom), 1'b1, 1'b0);
      if (i == len - 1 && !fin_empty) send_item(8'($urandom), 1'b0, 1'b1);
      else send_item(8'($urandom), 1'b0, 1'b0);
    end
    if (fin_empty || len == 0) send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'h63, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_block_edges();
    int lens [3] = '{55, 56, 64};
    foreach (lens[i]) send_message(lens[i], i[0], 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int count, int sidle, int rstall);
    int sent0;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    sent0 = items_sent;
    while (items_sent - sent0 < count) begin
      if ($urandom_range(9) == 0) send_message($urandom_range(40, 70), 1'b1, 1'b1);
      else send_message($urandom_range(1, 20), $urandom_range(1), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    byte_value = '0;
    no_data = 1'b0;
    is_final = 1'b0;
    out_ready = 1'b1;
    error_count = 0;
    items_sent = 0;
    digests_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hash_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_block_edges();
    test_random(30, 0, 0);
    test_random(30, 80, 0);
    test_random(30, 0, 80);
    test_random(30, 9, 9);
    repeat (300) @(negedge clk);
    $display("Run covered %0d input items and %0d complete digests under four loads.",
             items_sent, digests_seen);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("tb_sha256_stream_hasher_core: clean");
    end else begin
      $display("tb_sha256_stream_hasher_core: errors");
    end
    $finish;
  end

endmodule
